// ===== design/assert_macros.svh =====
// Assertion helpers, sampled on clk, held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/sac_pkg.sv =====
package sac_pkg;

  localparam int DELAY_W  = 25;
  localparam int ADDR_W   = 32;
  localparam int LAT_W    = 16;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 5;
  localparam int REGIDX_W = 3;

  localparam logic [DELAY_W-1:0] DELAY_MAX      = {DELAY_W{1'b1}};
  localparam logic [DELAY_W-1:0] DISABLED_DELAY = DELAY_W'(2);

  localparam logic [REGIDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_HIT_LAT    = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_MISS_LAT   = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_MISS_WB_LAT = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_WB_LAT     = 3'd4;

  localparam logic [LAT_W-1:0] HIT_LAT_RST     = 16'd1;
  localparam logic [LAT_W-1:0] MISS_LAT_RST    = 16'd10;
  localparam logic [LAT_W-1:0] MISS_WB_LAT_RST = 16'd20;
  localparam logic [LAT_W-1:0] WB_LAT_RST      = 16'd10;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_t;

endpackage

// ===== design/set_assoc_cache_tag_lru_timing_core.sv =====
// Access: on start the set row is read; in LOOKUP the row is compared and written
//   back and the result strobe is registered; busy holds off a new access in LOOKUP.
// Flush: one set row a cycle (next row read during write-back).
// Disabled: result registered directly from the accepted start. The receiver cannot stall; results are strobes.
// Reset (synchronous, rst_n low): control and config registers to defaults, then a
//   clearing pass of all 2^SET_BITS rows, busy high, before the first item is taken.
`include "assert_macros.svh"

module set_assoc_cache_tag_lru_timing_core
  import sac_pkg::*;
#(
  parameter int WAY_BITS  = 2,
  parameter int SET_BITS  = 6,
  parameter int LINE_BITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic                in_is_store,
  output logic                out_valid,
  output logic [DELAY_W-1:0]  out_delay,
  output logic                out_was_hit,
  output logic                out_did_writeback,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int NWAYS   = 1 << WAY_BITS;
  localparam int NSETS   = 1 << SET_BITS;
  localparam int TAG_LSB = LINE_BITS + SET_BITS;
  localparam int TAG_W   = ADDR_W - TAG_LSB;
  localparam int LRU_W   = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int WAY_IW  = LRU_W;
  localparam int SET_IW  = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int CNT_W   = SET_BITS + 1;
  localparam int DCNT_W  = WAY_BITS + 1;
  localparam int PROD_W  = DCNT_W + LAT_W;
  localparam int SUM_W   = DELAY_W + 1;
  localparam int ENT_W   = TAG_W + LRU_W + 2;
  localparam int ROW_W   = NWAYS * ENT_W;
  localparam int LRU_LSB = TAG_W;
  localparam int DRT_BIT = TAG_W + LRU_W;
  localparam int VLD_BIT = TAG_W + LRU_W + 1;
  localparam logic [LRU_W-1:0] LRU_MAX = LRU_W'(NWAYS - 1);

  // configuration registers
  logic              enable_r;
  logic [LAT_W-1:0]  hit_lat_r, miss_lat_r, miss_wb_lat_r, wb_lat_r;
  logic              cfg_wr;
  logic [REGIDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b1;
      hit_lat_r     <= HIT_LAT_RST;
      miss_lat_r    <= MISS_LAT_RST;
      miss_wb_lat_r <= MISS_WB_LAT_RST;
      wb_lat_r      <= WB_LAT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLE:      enable_r      <= pwdata[0];
        REG_HIT_LAT:     hit_lat_r     <= pwdata[LAT_W-1:0];
        REG_MISS_LAT:    miss_lat_r    <= pwdata[LAT_W-1:0];
        REG_MISS_WB_LAT: miss_wb_lat_r <= pwdata[LAT_W-1:0];
        REG_WB_LAT:      wb_lat_r      <= pwdata[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE:      prdata = PDATA_W'(enable_r);
      REG_HIT_LAT:     prdata = PDATA_W'(hit_lat_r);
      REG_MISS_LAT:    prdata = PDATA_W'(miss_lat_r);
      REG_MISS_WB_LAT: prdata = PDATA_W'(miss_wb_lat_r);
      REG_WB_LAT:      prdata = PDATA_W'(wb_lat_r);
      default:         prdata = '0;
    endcase
  end

  // set row memory: each row holds all ways {valid, dirty, lru, tag}
  logic [ROW_W-1:0]  row_mem [NSETS];
  logic [ROW_W-1:0]  rd_r;
  logic              rd_en, wr_en;
  logic [SET_IW-1:0] rd_idx, wr_idx;
  logic [ROW_W-1:0]  wr_row;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= row_mem[rd_idx];
    end
    if (wr_en) begin
      row_mem[wr_idx] <= wr_row;
    end
  end

  // control and payload registers
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DELAY_W-1:0] acc_r, acc_nxt;
  logic [SET_IW-1:0]  set_r, set_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic               store_r, store_nxt;
  logic               out_valid_r, ov_nxt;
  logic [DELAY_W-1:0] out_delay_r, od_nxt;
  logic               out_hit_r, oh_nxt;
  logic               out_wb_r, owb_nxt;

  logic               accept;
  logic [ADDR_W-1:0]  addr_sh;
  logic [SET_IW-1:0]  set_in;
  logic [TAG_W-1:0]   tag_in;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign addr_sh = in_address >> LINE_BITS;
  assign set_in  = addr_sh[SET_IW-1:0] & SET_IW'(NSETS - 1);
  assign tag_in  = TAG_W'(in_address >> TAG_LSB);

  // reset image of a row: LRU counter equals the way number
  logic [ROW_W-1:0] init_row;
  always_comb begin
    init_row = '0;
    for (int w = 0; w < NWAYS; w++) begin
      init_row[w*ENT_W + LRU_LSB +: LRU_W] = LRU_W'(w);
    end
  end

  // lookup of the set row just read
  logic [NWAYS-1:0]  vld_v, drt_v, hit_v;
  logic [LRU_W-1:0]  lru_a [NWAYS];
  logic              lk_hit, lk_dirty;
  logic [WAY_IW-1:0] hit_way, vic_way, acc_way;
  logic [LRU_W-1:0]  thresh;
  logic [ROW_W-1:0]  lk_row;
  logic [DELAY_W-1:0] lk_delay;

  always_comb begin
    lk_row  = rd_r;
    hit_way = '0;
    vic_way = '0;
    for (int w = 0; w < NWAYS; w++) begin
      vld_v[w] = rd_r[w*ENT_W + VLD_BIT];
      drt_v[w] = rd_r[w*ENT_W + DRT_BIT];
      lru_a[w] = rd_r[w*ENT_W + LRU_LSB +: LRU_W];
      hit_v[w] = vld_v[w] && (rd_r[w*ENT_W +: TAG_W] == tag_r);
    end
    // lowest matching way wins; no zero counter falls back to way 0
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (hit_v[w]) hit_way = WAY_IW'(w);
      if (lru_a[w] == '0) vic_way = WAY_IW'(w);
    end
    lk_hit   = |hit_v;
    acc_way  = lk_hit ? hit_way : vic_way;
    lk_dirty = !lk_hit && drt_v[vic_way];
    thresh   = lru_a[acc_way];
    for (int w = 0; w < NWAYS; w++) begin
      if (WAY_IW'(w) == acc_way) begin
        lk_row[w*ENT_W + LRU_LSB +: LRU_W] = LRU_MAX;
        lk_row[w*ENT_W + VLD_BIT]          = 1'b1;
        lk_row[w*ENT_W + DRT_BIT]          = lk_hit ? (drt_v[w] | store_r) : store_r;
        lk_row[w*ENT_W +: TAG_W]           = tag_r;
      end else if (lru_a[w] > thresh) begin
        lk_row[w*ENT_W + LRU_LSB +: LRU_W] = lru_a[w] - LRU_W'(1);
      end
    end
    if (lk_hit)        lk_delay = DELAY_W'(hit_lat_r);
    else if (lk_dirty) lk_delay = DELAY_W'(miss_wb_lat_r);
    else               lk_delay = DELAY_W'(miss_lat_r);
  end

  // flush of one row: clear dirty bits, add one per way and write-back cost per dirty way
  logic [DCNT_W-1:0]  dcnt;
  logic [ROW_W-1:0]   fl_row;
  logic [PROD_W-1:0]  fl_prod;
  logic [SUM_W-1:0]   fl_sum;
  logic [DELAY_W-1:0] fl_acc;

  always_comb begin
    fl_row = rd_r;
    dcnt   = '0;
    for (int w = 0; w < NWAYS; w++) begin
      dcnt = dcnt + DCNT_W'(drt_v[w]);
      fl_row[w*ENT_W + DRT_BIT] = 1'b0;
    end
    fl_prod = PROD_W'(dcnt) * PROD_W'(wb_lat_r);
    fl_sum  = {1'b0, acc_r} + SUM_W'(fl_prod) + SUM_W'(NWAYS);
    fl_acc  = fl_sum[DELAY_W] ? DELAY_MAX : fl_sum[DELAY_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    set_nxt   = set_r;
    tag_nxt   = tag_r;
    store_nxt = store_r;
    rd_en     = 1'b0;
    rd_idx    = set_in;
    wr_en     = 1'b0;
    wr_idx    = set_r;
    wr_row    = lk_row;
    ov_nxt    = 1'b0;
    od_nxt    = out_delay_r;
    oh_nxt    = 1'b0;
    owb_nxt   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en  = 1'b1;
        wr_idx = cnt_r[SET_IW-1:0];
        wr_row = init_row;
        if (cnt_r == CNT_W'(NSETS - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!enable_r) begin
            ov_nxt = 1'b1;
            od_nxt = in_func ? '0 : DISABLED_DELAY;
          end else if (in_func) begin
            rd_en     = 1'b1;
            rd_idx    = '0;
            set_nxt   = '0;
            cnt_nxt   = CNT_W'(1);
            acc_nxt   = '0;
            state_nxt = ST_FLUSH;
          end else begin
            rd_en     = 1'b1;
            set_nxt   = set_in;
            tag_nxt   = tag_in;
            store_nxt = in_is_store;
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        wr_en     = 1'b1;
        ov_nxt    = 1'b1;
        od_nxt    = lk_delay;
        oh_nxt    = lk_hit;
        owb_nxt   = lk_dirty;
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        wr_en   = 1'b1;
        wr_row  = fl_row;
        acc_nxt = fl_acc;
        if (cnt_r == CNT_W'(NSETS)) begin
          ov_nxt    = 1'b1;
          od_nxt    = fl_acc;
          state_nxt = ST_IDLE;
        end else begin
          // next row read overlaps write-back of the current one
          rd_en   = 1'b1;
          rd_idx  = cnt_r[SET_IW-1:0];
          set_nxt = cnt_r[SET_IW-1:0];
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    set_r       <= set_nxt;
    tag_r       <= tag_nxt;
    store_r     <= store_nxt;
    out_delay_r <= od_nxt;
    out_hit_r   <= oh_nxt;
    out_wb_r    <= owb_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_delay         = out_delay_r;
  assign out_was_hit       = out_hit_r;
  assign out_did_writeback = out_wb_r;

  `ASSERT_NEXT(a_lookup_gives_result, state_r == ST_LOOKUP, out_valid_r)
  `ASSERT_NOW(a_result_when_idle, out_valid_r, state_r == ST_IDLE)
  `ASSERT_NOW(a_hit_no_writeback, out_valid_r, !(out_hit_r && out_wb_r))

endmodule
